/* design/qgt_pkg.sv */
// shared constants, cordic angle table and pipeline payload type for the
// quaternion gravity / tilt unit; no dependencies
package qgt_pkg;

  // gravity sums are exact in units of 2^-28
  localparam int GW = 34;
  // cordic x / y datapath width, holds the gain growth of the largest vector
  localparam int CW = 36;
  // angle accumulator width, units of 2^-30 rad
  localparam int AW = 34;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN = 24;
  localparam int NUM_STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  localparam logic signed [AW-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [15:0] TILT_MAX = 16'sd25736;

  // atan(2^-i) * 2^30, truncated
  localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  // one item as it travels down the cordic stages
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] acc;
    logic                 zero;
    logic signed [15:0]   gx;
    logic signed [15:0]   gy;
    logic signed [15:0]   gz;
  } cordic_t;

endpackage

/* design/qgt_grav.sv */
// gravity front end: products, sums, q2.14 rounding and cordic setup
// in three register stages; uses qgt_pkg
module qgt_grav (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  logic signed [15:0]    q_w_i,
  input  logic signed [15:0]    q_x_i,
  input  logic signed [15:0]    q_y_i,
  input  logic signed [15:0]    q_z_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output qgt_pkg::cordic_t      data_o
);

  localparam int GW = qgt_pkg::GW;
  localparam int CW = qgt_pkg::CW;

  // round half up to q2.14, then saturate
  function automatic logic signed [15:0] sat_q14(input logic signed [GW-1:0] g);
    logic signed [GW:0] r;
    r = ((GW+1)'(g) + (GW+1)'(8192)) >>> 14;
    if (r < -32768) begin
      sat_q14 = -16'sd32768;
    end else if (r > 32767) begin
      sat_q14 = 16'sd32767;
    end else begin
      sat_q14 = 16'(r);
    end
  endfunction

  logic [2:0] vld_q;
  logic [2:0] en;

  assign en[2]   = !vld_q[2] || !stall_i;
  assign en[1]   = !vld_q[1] || en[2];
  assign en[0]   = !vld_q[0] || en[1];
  assign stall_o = !en[0];
  assign valid_o = vld_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= valid_i;
      if (en[1]) vld_q[1] <= vld_q[0];
      if (en[2]) vld_q[2] <= vld_q[1];
    end
  end

  // stage 1: the eight products
  logic signed [31:0] p_xz_q, p_wy_q, p_wx_q, p_yz_q;
  logic signed [31:0] p_ww_q, p_xx_q, p_yy_q, p_zz_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p_xz_q <= q_x_i * q_z_i;
      p_wy_q <= q_w_i * q_y_i;
      p_wx_q <= q_w_i * q_x_i;
      p_yz_q <= q_y_i * q_z_i;
      p_ww_q <= q_w_i * q_w_i;
      p_xx_q <= q_x_i * q_x_i;
      p_yy_q <= q_y_i * q_y_i;
      p_zz_q <= q_z_i * q_z_i;
    end
  end

  // stage 2: exact gravity sums
  logic signed [GW-1:0] gx_q, gy_q, gz_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      gx_q <= (GW'(p_xz_q) - GW'(p_wy_q)) <<< 1;
      gy_q <= (GW'(p_wx_q) + GW'(p_yz_q)) <<< 1;
      gz_q <= GW'(p_ww_q) - GW'(p_xx_q) - GW'(p_yy_q) + GW'(p_zz_q);
    end
  end

  // stage 3: saturated outputs and cordic start vector (-gy, -gz)
  qgt_pkg::cordic_t prep_d, prep_q;

  always_comb begin
    prep_d.gx   = sat_q14(gx_q);
    prep_d.gy   = sat_q14(gy_q);
    prep_d.gz   = sat_q14(gz_q);
    prep_d.zero = (gy_q == '0) && (gz_q == '0);
    if (gy_q > 0) begin
      // start vector in left half plane: reflect, preload +-pi
      prep_d.x   = CW'(gy_q);
      prep_d.y   = CW'(gz_q);
      prep_d.acc = (gz_q <= 0) ? qgt_pkg::PI_Q30 : -qgt_pkg::PI_Q30;
    end else begin
      prep_d.x   = -CW'(gy_q);
      prep_d.y   = -CW'(gz_q);
      prep_d.acc = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) prep_q <= prep_d;
  end

  assign data_o = prep_q;

endmodule

/* design/qgt_cordic.sv */
// unrolled vectoring cordic, one micro-rotation per register stage;
// uses qgt_pkg for widths, step count and the angle table
module qgt_cordic (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  qgt_pkg::cordic_t data_i,
  output logic             valid_o,
  input  logic             stall_i,
  output qgt_pkg::cordic_t data_o
);

  localparam int NS = qgt_pkg::NUM_STEPS;
  localparam int AW = qgt_pkg::AW;

  logic [NS-1:0]    vld_q;
  logic [NS-1:0]    en;
  qgt_pkg::cordic_t stg_q [NS];

  for (genvar i = 0; i < NS; i++) begin : g_step
    qgt_pkg::cordic_t src;
    qgt_pkg::cordic_t nxt;
    logic             src_vld;
    logic             en_nxt;

    if (i == 0) begin : g_first
      assign src     = data_i;
      assign src_vld = valid_i;
    end else begin : g_rest
      assign src     = stg_q[i-1];
      assign src_vld = vld_q[i-1];
    end

    if (i == NS - 1) begin : g_last
      assign en_nxt = !stall_i;
    end else begin : g_mid
      assign en_nxt = en[i+1];
    end

    assign en[i] = !vld_q[i] || en_nxt;

    always_comb begin
      nxt = src;
      if (src.y > 0) begin
        // rotate clockwise
        nxt.x   = src.x + (src.y >>> i);
        nxt.y   = src.y - (src.x >>> i);
        nxt.acc = src.acc + $signed({{(AW-32){1'b0}}, qgt_pkg::ATAN_Q30[i]});
      end else begin
        nxt.x   = src.x - (src.y >>> i);
        nxt.y   = src.y + (src.x >>> i);
        nxt.acc = src.acc - $signed({{(AW-32){1'b0}}, qgt_pkg::ATAN_Q30[i]});
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en[i]) begin
        vld_q[i] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[i]) stg_q[i] <= nxt;
    end
  end

  assign stall_o = !en[0];
  assign valid_o = vld_q[NS-1];
  assign data_o  = stg_q[NS-1];

endmodule

/* design/quaternion_gravity_tilt_unit.sv */
// top level of the quaternion gravity / tilt unit: front end, cordic and
// the output register with the q3.13 angle conversion; uses qgt_pkg,
// qgt_grav and qgt_cordic
//
//   channel  | direction | handshake             | beat payload
//   ---------+-----------+-----------------------+-----------------------------------
//   input    | in        | in_valid_i/in_stall_o | q_w_i q_x_i q_y_i q_z_i (q2.14)
//   output   | out       | out_valid_o/out_stall_i | grav_x_o grav_y_o grav_z_o tilt_angle_o
//
// one beat enters per cycle while in_stall_o is low; a beat passes through
// the three front-end stages, one stage per cordic micro-rotation and
// the output register
// every stage holds a valid bit and advances when it is empty or its
// successor advances, so bubbles are squeezed out under a stall and
// input is taken while a finished result waits in the output register
// reset clears the valid bits only; payload registers are not reset
module quaternion_gravity_tilt_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] q_w_i,
  input  logic signed [15:0] q_x_i,
  input  logic signed [15:0] q_y_i,
  input  logic signed [15:0] q_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] grav_x_o,
  output logic signed [15:0] grav_y_o,
  output logic signed [15:0] grav_z_o,
  output logic signed [15:0] tilt_angle_o
);

  localparam int AW = qgt_pkg::AW;

  // front end -> cordic
  logic             fe_valid;
  logic             fe_stall;
  qgt_pkg::cordic_t fe_data;

  // cordic -> output register
  logic             cd_valid;
  logic             cd_stall;
  qgt_pkg::cordic_t cd_data;

  qgt_grav u_grav (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .q_w_i   (q_w_i),
    .q_x_i   (q_x_i),
    .q_y_i   (q_y_i),
    .q_z_i   (q_z_i),
    .valid_o (fe_valid),
    .stall_i (fe_stall),
    .data_o  (fe_data)
  );

  qgt_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fe_valid),
    .stall_o (fe_stall),
    .data_i  (fe_data),
    .valid_o (cd_valid),
    .stall_i (cd_stall),
    .data_o  (cd_data)
  );

  // output stage: negate the accumulated angle, round 2^-30 -> 2^-13,
  // limit to +-pi; an all-zero (gy, gz) vector has no angle and gives 0
  logic               out_en;
  logic               out_vld_q;
  logic signed [AW:0] neg_ang;
  logic signed [AW:0] ang_sh;
  logic signed [15:0] tilt_d;
  logic signed [15:0] gx_q, gy_q, gz_q, tilt_q;

  assign out_en   = !out_vld_q || !out_stall_i;
  assign cd_stall = !out_en;

  always_comb begin
    neg_ang = (AW+1)'(65536) - (AW+1)'(cd_data.acc);
    ang_sh  = neg_ang >>> 17;
    if (cd_data.zero) begin
      tilt_d = '0;
    end else if (ang_sh > qgt_pkg::TILT_MAX) begin
      tilt_d = qgt_pkg::TILT_MAX;
    end else if (ang_sh < -qgt_pkg::TILT_MAX) begin
      tilt_d = -qgt_pkg::TILT_MAX;
    end else begin
      tilt_d = 16'(ang_sh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_en) begin
      out_vld_q <= cd_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      gx_q   <= cd_data.gx;
      gy_q   <= cd_data.gy;
      gz_q   <= cd_data.gz;
      tilt_q <= tilt_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign grav_x_o     = gx_q;
  assign grav_y_o     = gy_q;
  assign grav_z_o     = gz_q;
  assign tilt_angle_o = tilt_q;

`ifndef SYNTHESIS
  // an empty output register means the whole pipeline can move
  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output register empty");

  // back-pressure at the input only comes from a full, stalled output
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stall without output back-pressure");

  // delivered tilt stays within +-pi in q3.13
  a_tilt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tilt_angle_o <= qgt_pkg::TILT_MAX &&
                     tilt_angle_o >= -qgt_pkg::TILT_MAX))
    else $error("tilt angle out of range");
`endif

endmodule
